// File: hw/rtl/hit_datagram_parser_assert.svh
// Assertion macros for the checker of the hit datagram parser.
`ifndef HIT_DATAGRAM_PARSER_ASSERT_SVH
`define HIT_DATAGRAM_PARSER_ASSERT_SVH

// Checked at every rising clock edge outside reset.
`define HDP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define HDP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/hdp_pkg.sv
// Types and constants shared by the hit datagram parser modules.
package hdp_pkg;

  localparam int EVENT_COUNT_BITS = 32;

  localparam logic [7:0] MARK_BYTE = 8'hFA;
  localparam logic [10:0] LOW_CHARGE_CODE = 11'd1025;

  localparam logic KIND_HIT = 1'b0;
  localparam logic KIND_BOUNDARY = 1'b1;

  localparam logic CFG_USE_STRIP_MAP = 1'b0;
  localparam logic CFG_FLAG_LOW_CHARGE = 1'b1;

  typedef struct packed {
    logic use_strip_map;
    logic flag_low_charge;
  } cfg_t;

  typedef struct packed {
    logic kind;
    logic [7:0] chip_number;
    logic [15:0] trigger_count;
    logic [15:0] trigger_time;
    logic [63:0] hit_word;
    logic [31:0] event_number;
  } packet_t;

  typedef struct packed {
    logic kind;
    logic [7:0] chip_number;
    logic [15:0] trigger_count;
    logic [15:0] trigger_time;
    logic hit_flag;
    logic over_threshold;
    logic [7:0] channel;
    logic [10:0] charge;
    logic [7:0] time_value;
    logic [11:0] bunch_gray;
    logic [11:0] bunch_binary;
    logic [31:0] event_number;
  } result_t;

endpackage

// File: hw/rtl/hdp_framer.sv
// Byte framer: tracks datagram position, captures the header, assembles hits and spots boundary datagrams.
module hdp_framer
  import hdp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic [7:0] data_byte,
  input  logic last_byte,
  input  logic byte_valid,
  output logic byte_stall,
  input  logic packet_take,
  output logic packet_valid,
  output packet_t packet
);

  localparam logic [3:0] HEADER_LEN = 4'd12;
  localparam logic [3:0] MARKER_LEN = 4'd4;
  localparam logic [3:0] POS_CHIP = 4'd7;
  localparam logic [3:0] POS_COUNT_HI = 4'd8;
  localparam logic [3:0] POS_COUNT_LO = 4'd9;
  localparam logic [3:0] POS_TIME_HI = 4'd10;
  localparam logic [3:0] POS_TIME_LO = 4'd11;
  localparam logic [2:0] HIT_LAST = 3'd7;

  logic [3:0] header_position;
  logic [2:0] hit_byte_index;
  logic marker_so_far;
  logic [7:0] chip_reg;
  logic [15:0] trigger_count_reg;
  logic [15:0] trigger_time_reg;
  logic [55:0] hit_bytes;
  logic [EVENT_COUNT_BITS-1:0] boundary_count;

  logic accept;
  logic in_header;
  logic in_hits;
  logic marker_next;
  logic [3:0] position_next;
  logic hit_done;
  logic boundary;

  assign byte_stall = packet_valid && !packet_take;
  assign accept = byte_valid && !byte_stall;

  assign in_header = header_position < HEADER_LEN;
  assign in_hits = !in_header && !marker_so_far;
  assign marker_next = marker_so_far &&
                       !((header_position < MARKER_LEN) && (data_byte != MARK_BYTE));
  assign position_next = in_header ? header_position + 4'd1 : header_position;
  assign hit_done = in_hits && (hit_byte_index == HIT_LAST);
  assign boundary = last_byte && marker_next && (position_next >= MARKER_LEN);

  always_ff @(posedge clk) begin
    if (rst) begin
      header_position <= '0;
      hit_byte_index <= '0;
      marker_so_far <= 1'b1;
      chip_reg <= '0;
      trigger_count_reg <= '0;
      trigger_time_reg <= '0;
      hit_bytes <= '0;
      boundary_count <= '0;
    end else if (accept) begin
      if (in_header) begin
        unique case (header_position)
          POS_CHIP: chip_reg <= data_byte;
          POS_COUNT_HI: trigger_count_reg[15:8] <= data_byte;
          POS_COUNT_LO: trigger_count_reg[7:0] <= data_byte;
          POS_TIME_HI: trigger_time_reg[15:8] <= data_byte;
          POS_TIME_LO: trigger_time_reg[7:0] <= data_byte;
          default: ;
        endcase
      end
      if (hit_done) begin
        hit_byte_index <= '0;
        hit_bytes <= '0;
      end else if (in_hits) begin
        hit_byte_index <= hit_byte_index + 3'd1;
        hit_bytes <= {hit_bytes[47:0], data_byte};
      end
      if (boundary) begin
        boundary_count <= boundary_count + EVENT_COUNT_BITS'(1);
      end
      if (last_byte) begin
        header_position <= '0;
        hit_byte_index <= '0;
        hit_bytes <= '0;
        marker_so_far <= 1'b1;
      end else begin
        header_position <= position_next;
        marker_so_far <= marker_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_valid <= 1'b0;
    end else if (accept) begin
      packet_valid <= hit_done || boundary;
    end else if (packet_take) begin
      packet_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      packet.kind <= boundary ? KIND_BOUNDARY : KIND_HIT;
      packet.chip_number <= chip_reg;
      packet.trigger_count <= trigger_count_reg;
      packet.trigger_time <= trigger_time_reg;
      packet.hit_word <= {hit_bytes, data_byte};
      packet.event_number <= 32'(boundary_count);
    end
  end

endmodule

// File: hw/rtl/hdp_decode.sv
// Hit decoder: unscrambles one 8-byte hit word into its result fields, or passes a boundary's event number.
module hdp_decode
  import hdp_pkg::*;
(
  input  packet_t packet,
  input  cfg_t cfg,
  output result_t result
);

  logic [31:0] w1;
  logic [31:0] w2;
  logic [5:0] chip_channel;
  logic [4:0] half;
  logic [7:0] strip;
  logic [9:0] raw_charge;
  logic [11:0] gray;
  logic [11:0] binary;

  assign w1 = packet.hit_word[63:32];
  assign w2 = packet.hit_word[31:0];

  assign chip_channel = {w2[24], w2[25], w2[26], w2[27], w2[28], w2[29]};
  assign half = chip_channel[5:1];

  always_comb begin
    strip = 8'd0;
    if (!packet.chip_number[0] && (packet.chip_number <= 8'd14)) begin
      strip = chip_channel[0] ? 8'd33 + {3'b000, half} : 8'd32 - {3'b000, half};
    end else if (packet.chip_number[0] && (packet.chip_number <= 8'd15)) begin
      strip = chip_channel[0] ? 8'd65 + {3'b000, half} : 8'd128 - {3'b000, half};
    end
  end

  assign raw_charge = {w1[14], w1[15], w1[0], w1[1], w1[2], w1[3],
                       w1[4], w1[5], w1[6], w1[7]};
  assign gray = {w1[26], w1[27], w1[28], w1[29], w1[30], w1[31],
                 w1[16], w1[17], w1[18], w1[19], w1[20], w1[21]};

  always_comb begin
    for (int i = 0; i < 12; i++) begin
      binary[i] = ^(gray >> i);
    end
  end

  always_comb begin
    result = '0;
    result.kind = packet.kind;
    if (packet.kind == KIND_BOUNDARY) begin
      result.event_number = packet.event_number;
    end else begin
      result.chip_number = packet.chip_number;
      result.trigger_count = packet.trigger_count;
      result.trigger_time = packet.trigger_time;
      result.hit_flag = w2[31];
      result.over_threshold = w2[30];
      result.channel = cfg.use_strip_map ? strip : {2'b00, chip_channel};
      result.charge = (cfg.flag_low_charge && (raw_charge[3:0] == 4'd0)) ?
                      LOW_CHARGE_CODE : {1'b0, raw_charge};
      result.time_value = {w1[22], w1[23], w1[8], w1[9], w1[10], w1[11], w1[12], w1[13]};
      result.bunch_gray = gray;
      result.bunch_binary = binary;
    end
  end

endmodule

// File: hw/rtl/hit_datagram_parser.sv
// Top level of the hit datagram parser: configuration, framer, decoder, result register.
// The parser takes one datagram byte per cycle with no gaps of its own; it only stalls the
// byte side while a result waits on a stalled output. A result leaves through the framer's
// packet register and the result register. A datagram opening with four FA bytes gives no
// hit results but one boundary result on its last byte with the event number; any other
// datagram gives one hit result for each complete 8-byte hit after the 12-byte header.
module hit_datagram_parser
  import hdp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  logic cfg_index,
  input  logic cfg_data,
  input  logic [7:0] data_byte,
  input  logic last_byte,
  input  logic byte_valid,
  output logic byte_stall,
  output logic result_valid,
  input  logic result_stall,
  output logic kind,
  output logic [7:0] chip_number,
  output logic [15:0] trigger_count,
  output logic [15:0] trigger_time,
  output logic hit_flag,
  output logic over_threshold,
  output logic [7:0] channel,
  output logic [10:0] charge,
  output logic [7:0] time_value,
  output logic [11:0] bunch_gray,
  output logic [11:0] bunch_binary,
  output logic [31:0] event_number
);

  cfg_t cfg;
  packet_t packet;
  logic packet_valid;
  logic packet_take;
  result_t decoded;
  result_t result;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_USE_STRIP_MAP: cfg.use_strip_map <= cfg_data;
        CFG_FLAG_LOW_CHARGE: cfg.flag_low_charge <= cfg_data;
        default: ;
      endcase
    end
  end

  assign packet_take = !result_valid || !result_stall;

  hdp_framer u_framer (
    .clk(clk),
    .rst(rst),
    .data_byte(data_byte),
    .last_byte(last_byte),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .packet_take(packet_take),
    .packet_valid(packet_valid),
    .packet(packet)
  );

  hdp_decode u_decode (
    .packet(packet),
    .cfg(cfg),
    .result(decoded)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (packet_take) begin
      result_valid <= packet_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (packet_take && packet_valid) begin
      result <= decoded;
    end
  end

  assign kind = result.kind;
  assign chip_number = result.chip_number;
  assign trigger_count = result.trigger_count;
  assign trigger_time = result.trigger_time;
  assign hit_flag = result.hit_flag;
  assign over_threshold = result.over_threshold;
  assign channel = result.channel;
  assign charge = result.charge;
  assign time_value = result.time_value;
  assign bunch_gray = result.bunch_gray;
  assign bunch_binary = result.bunch_binary;
  assign event_number = result.event_number;

endmodule

// File: hw/rtl/hdp_checker.sv
// Port-level checker for the hit datagram parser, bound to its top level.
`include "hit_datagram_parser_assert.svh"

module hdp_checker
  import hdp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic result_valid,
  input  logic result_stall,
  input  logic kind,
  input  logic [7:0] chip_number,
  input  logic [15:0] trigger_count,
  input  logic [15:0] trigger_time,
  input  logic [7:0] channel,
  input  logic [10:0] charge,
  input  logic [31:0] event_number
);

  `HDP_ASSERT_ALWAYS(a_idle_after_reset, rst |=> !result_valid, "result valid after reset")
  `HDP_ASSERT(a_boundary_clean, (result_valid && kind == KIND_BOUNDARY) |-> (chip_number == 8'd0 && trigger_count == 16'd0 && trigger_time == 16'd0 && channel == 8'd0 && charge == 11'd0), "boundary item carries hit fields")
  `HDP_ASSERT(a_hit_no_event, (result_valid && kind == KIND_HIT) |-> (event_number == 32'd0 && channel <= 8'd128 && charge <= LOW_CHARGE_CODE), "hit item fields out of range")
  `HDP_ASSERT(a_stall_holds, (result_valid && result_stall) |=> (result_valid && $stable(kind) && $stable(charge) && $stable(event_number)), "stalled result item changed")

endmodule

bind hit_datagram_parser hdp_checker u_checker (.*);

// File: tb/sv/hit_datagram_parser_tb.sv
// Self-checking testbench for the hit datagram parser, with its own byte-level decoder.
`timescale 1ns / 100ps

module hit_datagram_parser_tb;
  import hdp_pkg::*;

  localparam int PHASES = 6;
  localparam int PHASE_BYTES = 255;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 200000;

  localparam result_t FIRST_BOUNDARY = '{kind: KIND_BOUNDARY, default: '0};
  localparam result_t ALL_ONES_HIT = '{
    kind: KIND_HIT, chip_number: 8'hFF, trigger_count: 16'hFFFF, trigger_time: 16'hFFFF,
    hit_flag: 1'b1, over_threshold: 1'b1, channel: 8'd63, charge: 11'd1023,
    time_value: 8'hFF, bunch_gray: 12'hFFF, bunch_binary: 12'hAAA, event_number: 32'd0};

  typedef struct packed {
    logic [7:0] data;
    logic last;
    logic typed;
    result_t want;
  } stim_row_t;

  logic clk;
  logic rst;
  logic cfg_write;
  logic cfg_index;
  logic cfg_data;
  logic [7:0] data_byte;
  logic last_byte;
  logic byte_valid;
  logic byte_stall;
  logic result_valid;
  logic result_stall;
  logic kind;
  logic [7:0] chip_number;
  logic [15:0] trigger_count;
  logic [15:0] trigger_time;
  logic hit_flag;
  logic over_threshold;
  logic [7:0] channel;
  logic [10:0] charge;
  logic [7:0] time_value;
  logic [11:0] bunch_gray;
  logic [11:0] bunch_binary;
  logic [31:0] event_number;

  // Decoder state and configuration.
  logic strip_on;
  logic low_charge_on;
  logic [3:0] hdr_pos;
  logic [2:0] hit_idx;
  logic all_mark;
  logic [7:0] chip_q;
  logic [15:0] trig_count_q;
  logic [15:0] trig_time_q;
  logic [55:0] hit_shift;
  logic [31:0] boundary_q;

  result_t pending_results[$];
  int mismatches;
  int cycles;
  int sender_idle_pct;
  int receiver_idle_pct;
  int hold_left;
  int bytes_sent;

  stim_row_t directed_rows [0:25] = '{
    '{8'hFA, 1'b0, 1'b0, '0},
    '{8'hFA, 1'b0, 1'b0, '0},
    '{8'hFA, 1'b0, 1'b0, '0},
    '{8'hFA, 1'b1, 1'b1, FIRST_BOUNDARY},
    '{8'hFA, 1'b0, 1'b0, '0},
    '{8'hFA, 1'b1, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b1, 1'b1, ALL_ONES_HIT}
  };

  hit_datagram_parser dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .data_byte(data_byte),
    .last_byte(last_byte),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .kind(kind),
    .chip_number(chip_number),
    .trigger_count(trigger_count),
    .trigger_time(trigger_time),
    .hit_flag(hit_flag),
    .over_threshold(over_threshold),
    .channel(channel),
    .charge(charge),
    .time_value(time_value),
    .bunch_gray(bunch_gray),
    .bunch_binary(bunch_binary),
    .event_number(event_number)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic bit parse_byte(input logic [7:0] b, input logic last,
                                    output result_t r);
    logic [63:0] full;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [5:0] ch6;
    logic [4:0] half;
    logic [10:0] chg;
    logic [11:0] gray;
    logic [11:0] bin;
    bit produced;
    r = '0;
    produced = 1'b0;
    if (hdr_pos < 4'd12) begin
      if (hdr_pos < 4'd4 && b != MARK_BYTE) all_mark = 1'b0;
      case (hdr_pos)
        4'd7: chip_q = b;
        4'd8: trig_count_q[15:8] = b;
        4'd9: trig_count_q[7:0] = b;
        4'd10: trig_time_q[15:8] = b;
        4'd11: trig_time_q[7:0] = b;
        default: ;
      endcase
      hdr_pos = hdr_pos + 4'd1;
    end else if (!all_mark) begin
      if (hit_idx == 3'd7) begin
        full = {hit_shift, b};
        w1 = full[63:32];
        w2 = full[31:0];
        ch6 = {w2[24], w2[25], w2[26], w2[27], w2[28], w2[29]};
        half = ch6[5:1];
        if (!strip_on) r.channel = {2'b00, ch6};
        else if (!chip_q[0] && chip_q <= 8'd14)
          r.channel = ch6[0] ? 8'd33 + {3'b000, half} : 8'd32 - {3'b000, half};
        else if (chip_q[0] && chip_q <= 8'd15)
          r.channel = ch6[0] ? 8'd65 + {3'b000, half} : 8'd128 - {3'b000, half};
        else r.channel = 8'd0;
        chg = {1'b0, w1[14], w1[15], w1[0], w1[1], w1[2], w1[3], w1[4], w1[5], w1[6], w1[7]};
        if (low_charge_on && chg[3:0] == 4'd0) chg = LOW_CHARGE_CODE;
        gray = {w1[26], w1[27], w1[28], w1[29], w1[30], w1[31],
                w1[16], w1[17], w1[18], w1[19], w1[20], w1[21]};
        bin[11] = gray[11];
        for (int i = 10; i >= 0; i--) bin[i] = bin[i + 1] ^ gray[i];
        r.kind = KIND_HIT;
        r.chip_number = chip_q;
        r.trigger_count = trig_count_q;
        r.trigger_time = trig_time_q;
        r.hit_flag = w2[31];
        r.over_threshold = w2[30];
        r.charge = chg;
        r.time_value = {w1[22], w1[23], w1[8], w1[9], w1[10], w1[11], w1[12], w1[13]};
        r.bunch_gray = gray;
        r.bunch_binary = bin;
        produced = 1'b1;
        hit_idx = 3'd0;
        hit_shift = '0;
      end else begin
        hit_shift = {hit_shift[47:0], b};
        hit_idx = hit_idx + 3'd1;
      end
    end
    if (last) begin
      if (all_mark && hdr_pos >= 4'd4) begin
        r = '0;
        r.kind = KIND_BOUNDARY;
        r.event_number = boundary_q;
        boundary_q = boundary_q + 32'd1;
        produced = 1'b1;
      end
      hdr_pos = 4'd0;
      hit_idx = 3'd0;
      hit_shift = '0;
      all_mark = 1'b1;
    end
    return produced;
  endfunction

  task automatic report(input string msg);
    $display("ERROR at cycle %0d: %s", cycles, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) report($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  // Called at a falling edge; returns at the falling edge after the item is accepted.
  task automatic push_byte(input logic [7:0] b, input logic last, input logic typed,
                           input result_t typed_want);
    result_t predicted;
    bit produced;
    while ($urandom_range(99) < sender_idle_pct) begin
      byte_valid <= 1'b0;
      @(negedge clk);
    end
    byte_valid <= 1'b1;
    data_byte <= b;
    last_byte <= last;
    do @(posedge clk); while (byte_stall);
    produced = parse_byte(b, last, predicted);
    if (typed) pending_results = {pending_results, typed_want};
    else if (produced) pending_results = {pending_results, predicted};
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic write_config(input logic strip, input logic low);
    cfg_write <= 1'b1;
    cfg_index <= CFG_USE_STRIP_MAP;
    cfg_data <= strip;
    @(negedge clk);
    cfg_index <= CFG_FLAG_LOW_CHARGE;
    cfg_data <= low;
    @(negedge clk);
    cfg_write <= 1'b0;
    strip_on = strip;
    low_charge_on = low;
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic send_datagram();
    logic [7:0] dgram[$];
    int shape;
    int nhits;
    shape = $urandom_range(99);
    if (shape < 14) begin
      repeat (4) dgram = {dgram, MARK_BYTE};
      repeat ($urandom_range(12)) dgram = {dgram, 8'($urandom)};
    end else if (shape < 24) begin
      repeat ($urandom_range(1, 14))
        dgram = {dgram, ($urandom_range(2) == 0) ? MARK_BYTE : 8'($urandom)};
    end else begin
      repeat (12) dgram = {dgram, 8'($urandom)};
      if ($urandom_range(3) == 0)
        for (int i = 0; i < 3; i++) dgram[i] = MARK_BYTE;
      if (dgram[0] == MARK_BYTE && dgram[1] == MARK_BYTE && dgram[2] == MARK_BYTE &&
          dgram[3] == MARK_BYTE)
        dgram[3] = dgram[3] ^ 8'h01;
      if ($urandom_range(3) != 0) dgram[7] = 8'($urandom_range(17));
      nhits = $urandom_range(4);
      for (int h = 0; h < nhits; h++) begin
        for (int k = 0; k < 8; k++) begin
          dgram = {dgram, 8'($urandom)};
          if (k == 3 && $urandom_range(3) == 0) dgram[dgram.size() - 1][7:4] = 4'd0;
        end
      end
      if ($urandom_range(3) == 0) repeat ($urandom_range(1, 7)) dgram = {dgram, 8'($urandom)};
    end
    foreach (dgram[i]) push_byte(dgram[i], i == dgram.size() - 1, 1'b0, '0);
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      result_stall <= ($urandom_range(99) < receiver_idle_pct);
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
    if (!rst && result_valid && !result_stall) begin
      got = '{kind, chip_number, trigger_count, trigger_time, hit_flag, over_threshold,
              channel, charge, time_value, bunch_gray, bunch_binary, event_number};
      if (pending_results.size() == 0) begin
        report("result arrived with none expected");
      end else begin
        want = pending_results.pop_front();
        check_field("kind", 32'(got.kind), 32'(want.kind));
        check_field("chip_number", 32'(got.chip_number), 32'(want.chip_number));
        check_field("trigger_count", 32'(got.trigger_count), 32'(want.trigger_count));
        check_field("trigger_time", 32'(got.trigger_time), 32'(want.trigger_time));
        check_field("hit_flag", 32'(got.hit_flag), 32'(want.hit_flag));
        check_field("over_threshold", 32'(got.over_threshold), 32'(want.over_threshold));
        check_field("channel", 32'(got.channel), 32'(want.channel));
        check_field("charge", 32'(got.charge), 32'(want.charge));
        check_field("time_value", 32'(got.time_value), 32'(want.time_value));
        check_field("bunch_gray", 32'(got.bunch_gray), 32'(want.bunch_gray));
        check_field("bunch_binary", 32'(got.bunch_binary), 32'(want.bunch_binary));
        check_field("event_number", got.event_number, want.event_number);
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = CFG_USE_STRIP_MAP;
    cfg_data = 1'b0;
    data_byte = 8'h00;
    last_byte = 1'b0;
    byte_valid = 1'b0;
    result_stall = 1'b0;
    mismatches = 0;
    cycles = 0;
    hold_left = 0;
    bytes_sent = 0;
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    strip_on = 1'b0;
    low_charge_on = 1'b0;
    hdr_pos = 4'd0;
    hit_idx = 3'd0;
    all_mark = 1'b1;
    chip_q = '0;
    trig_count_q = '0;
    trig_time_q = '0;
    hit_shift = '0;
    boundary_q = '0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    write_config(1'b0, 1'b0);

    sender_idle_pct = 7;
    receiver_idle_pct = 46;
    foreach (directed_rows[i])
      push_byte(directed_rows[i].data, directed_rows[i].last, directed_rows[i].typed,
                directed_rows[i].want);
    byte_valid <= 1'b0;
    drain_results();

    for (int p = 0; p < PHASES; p++) begin
      write_config(p[0], p[1]);
      case (p / 2)
        0: begin
          sender_idle_pct = 7;
          receiver_idle_pct = 46;
        end
        1: begin
          sender_idle_pct = 46;
          receiver_idle_pct = 7;
        end
        default: begin
          sender_idle_pct = 0;
          receiver_idle_pct = 0;
        end
      endcase
      if (p == 1) begin
        @(posedge clk);
        hold_left = HOLD_CYCLES;
        @(negedge clk);
      end
      bytes_sent = 0;
      while (bytes_sent < PHASE_BYTES) send_datagram();
      byte_valid <= 1'b0;
      drain_results();
    end

    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
